@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/enbm_pkg.sv @@
package enbm_pkg;

    localparam int LABEL_BITS    = 16;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int WIDTH_FIELD_W = 11;
    localparam int HEIGHT_W      = 16;
    localparam int MASK_W        = 8;
    localparam int ROW_W         = 2;
    localparam int MIN_DIM       = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_HEIGHT = 2'd1;

    // saturating row position codes
    localparam logic [ROW_W-1:0] ROW_FIRST  = 2'd0;
    localparam logic [ROW_W-1:0] ROW_SECOND = 2'd1;
    localparam logic [ROW_W-1:0] ROW_LATER  = 2'd2;

    // neighbour bits of the mask
    localparam logic [MASK_W-1:0] MASK_ALL = 8'd255;
    localparam logic [MASK_W-1:0] MASK_N   = 8'd1;
    localparam logic [MASK_W-1:0] MASK_NW  = 8'd2;
    localparam logic [MASK_W-1:0] MASK_W_  = 8'd4;
    localparam logic [MASK_W-1:0] MASK_SW  = 8'd8;
    localparam logic [MASK_W-1:0] MASK_S   = 8'd16;
    localparam logic [MASK_W-1:0] MASK_SE  = 8'd32;
    localparam logic [MASK_W-1:0] MASK_E   = 8'd64;
    localparam logic [MASK_W-1:0] MASK_NE  = 8'd128;

    typedef struct packed {
        logic signed [LABEL_BITS-1:0] label;
        logic                         is_pad;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] border_mask;
        logic              end_of_frame;
    } t_out_word;

    // per-item control from the position counters
    typedef struct packed {
        logic emit;
        logic west_in;
        logic east_in;
        logic north_in;
        logic south_in;
        logic eof;
    } t_ctl;

endpackage

@@ src/enbm_ram.sv @@
module enbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/enbm_ctrl.sv @@
`include "assert_macros.svh"

module enbm_ctrl #(
    parameter int MAX_WIDTH = enbm_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [enbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [enbm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_acc,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_col,
    output enbm_pkg::t_ctl                 o_ctl
);

    import enbm_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int PROD_W = WCNT_W + HEIGHT_W;

    logic [WCNT_W-1:0]   r_w, n_w, w_sat;
    logic [HEIGHT_W-1:0] r_h, n_h, h_sat;
    logic [PROD_W-1:0]   r_last, r_slim, prod;
    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [PROD_W-1:0]   r_emit, n_emit;
    logic [WIDTH_FIELD_W-1:0] width_raw;
    logic cfg_hit, col_zero, col_last, have_a, have_b;

    // register write with saturation
    always_comb begin
        width_raw = i_cfg_data[WIDTH_FIELD_W-1:0];
        if (32'(width_raw) < 32'(MIN_DIM)) begin
            w_sat = WCNT_W'(MIN_DIM);
        end else if (32'(width_raw) > 32'(MAX_WIDTH)) begin
            w_sat = WCNT_W'(MAX_WIDTH);
        end else begin
            w_sat = WCNT_W'(width_raw);
        end
        if (32'(i_cfg_data[HEIGHT_W-1:0]) < 32'(MIN_DIM)) begin
            h_sat = HEIGHT_W'(MIN_DIM);
        end else begin
            h_sat = i_cfg_data[HEIGHT_W-1:0];
        end
        n_w     = r_w;
        n_h     = r_h;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RASTER_WIDTH: begin
                    n_w     = w_sat;
                    cfg_hit = 1'b1;
                end
                CFG_RASTER_HEIGHT: begin
                    n_h     = h_sat;
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        prod = PROD_W'(n_w) * PROD_W'(n_h);
    end

    // flags of the item at the current position
    always_comb begin
        col_zero       = (r_col == '0);
        col_last       = (WCNT_W'(r_col) == r_w - WCNT_W'(1));
        have_a         = col_zero && (r_row == ROW_LATER);
        have_b         = !col_zero && (r_row != ROW_FIRST);
        o_ctl.emit     = have_a || have_b;
        o_ctl.west_in  = have_a || (r_col > COL_W'(1));
        o_ctl.east_in  = have_b;
        o_ctl.north_in = (r_emit >= PROD_W'(r_w));
        o_ctl.south_in = (r_emit < r_slim);
        o_ctl.eof      = (r_emit == r_last);
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_emit = r_emit;
        if (cfg_hit) begin
            n_col  = '0;
            n_row  = ROW_FIRST;
            n_emit = '0;
        end else if (i_acc) begin
            if (o_ctl.emit && o_ctl.eof) begin
                n_col  = '0;
                n_row  = ROW_FIRST;
                n_emit = '0;
            end else begin
                if (o_ctl.emit) begin
                    n_emit = r_emit + PROD_W'(1);
                end
                if (col_last) begin
                    n_col = '0;
                    if (r_row != ROW_LATER) begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= WCNT_W'(MIN_DIM);
            r_h    <= HEIGHT_W'(MIN_DIM);
            r_last <= PROD_W'(MIN_DIM * MIN_DIM - 1);
            r_slim <= PROD_W'(MIN_DIM * (MIN_DIM - 1));
            r_col  <= '0;
            r_row  <= ROW_FIRST;
            r_emit <= '0;
        end else begin
            if (cfg_hit) begin
                r_w    <= n_w;
                r_h    <= n_h;
                r_last <= prod - PROD_W'(1);
                r_slim <= prod - PROD_W'(n_w);
            end
            r_col  <= n_col;
            r_row  <= n_row;
            r_emit <= n_emit;
        end
    end

    assign o_col = r_col;

    `ASSERT_NEXT(a_eof_restart, i_clk, i_rst_n, i_acc && !cfg_hit && o_ctl.emit && o_ctl.eof, r_col == '0 && r_emit == '0 && r_row == ROW_FIRST)
    `ASSERT_IMPLY(a_emit_bound, i_clk, i_rst_n, i_acc, r_emit <= r_last)

endmodule

@@ src/enbm_window.sv @@
module enbm_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  enbm_pkg::t_ctl                 i_ctl,
    input  logic [enbm_pkg::LABEL_BITS-1:0] i_top,
    input  logic [enbm_pkg::LABEL_BITS-1:0] i_mid,
    input  logic [enbm_pkg::LABEL_BITS-1:0] i_lab,
    output logic [enbm_pkg::MASK_W-1:0]     o_mask
);

    import enbm_pkg::*;

    // rows north, centre, south; columns west, centre
    logic [LABEL_BITS-1:0] r_win [3][2];
    logic [LABEL_BITS-1:0] ctr;
    logic [MASK_W-1:0]     same;

    always_comb begin
        ctr  = r_win[1][1];
        same = '0;
        if (i_ctl.north_in && r_win[0][1] == ctr) same = same | MASK_N;
        if (i_ctl.south_in && r_win[2][1] == ctr) same = same | MASK_S;
        if (i_ctl.west_in) begin
            if (r_win[1][0] == ctr)                    same = same | MASK_W_;
            if (i_ctl.north_in && r_win[0][0] == ctr) same = same | MASK_NW;
            if (i_ctl.south_in && r_win[2][0] == ctr) same = same | MASK_SW;
        end
        if (i_ctl.east_in) begin
            if (i_mid == ctr)                    same = same | MASK_E;
            if (i_ctl.north_in && i_top == ctr) same = same | MASK_NE;
            if (i_ctl.south_in && i_lab == ctr) same = same | MASK_SE;
        end
        o_mask = MASK_ALL & ~same;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= '0;
                r_win[r][1] <= '0;
            end
        end else if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
            end
            r_win[0][1] <= i_top;
            r_win[1][1] <= i_mid;
            r_win[2][1] <= i_lab;
        end
    end

endmodule

@@ src/eight_neighbour_border_mask.sv @@
// eight-neighbour border mask over a streamed label raster
// input channel: one word per raster cell in row-major order, row 0 at the north,
//   followed by raster_width+1 pad words (is_pad=1) to flush the last cells
// output channel: one word (border_mask, end_of_frame) per cell; cell (r,c) is
//   produced by the input word at stream position (r+1)*width + c + 1
// config channel: index 0 raster_width, index 1 raster_height, always ready;
//   a write restarts the frame position; the user makes it only while the block is idle, unenforced
// throughput: one word per cycle outside a stall; the two line buffers share one
//   dual-port ram, read at acceptance and written back one stage later
// path: the triggering input word passes the ram read stage, then the output
//   register, which presents its output word until the word is taken
// stall: when the output register holds an untaken word, a read-stage word with a
//   result holds and input ready drops; a word that produces nothing still flows
// reset: synchronous, active low; sizes return to 2x2 and the frame position
//   to zero; line buffer contents stay undefined and need no clearing pass
`include "assert_macros.svh"

module eight_neighbour_border_mask #(
    parameter int MAX_WIDTH = enbm_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  enbm_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output enbm_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [enbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [enbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import enbm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    // handshake
    logic in_acc, s1_adv, out_free;

    // position of the incoming word
    logic [COL_W-1:0] ctl_col;
    t_ctl             ctl;

    // read stage: ram data lands alongside these
    logic             r_s1_valid;
    t_ctl             r_s1_ctl;
    logic [COL_W-1:0] r_s1_col;
    logic [LABEL_BITS-1:0] r_s1_lab;

    // line buffers: upper row in the high half, middle row in the low half
    logic [2*LABEL_BITS-1:0] line_rdata;
    logic [LABEL_BITS-1:0]   rd_top, rd_mid, in_lab;

    logic [MASK_W-1:0] mask;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    assign o_cfg_ready = 1'b1;

    // a pad word carries label zero
    assign in_lab = i_in_word.is_pad ? '0 : i_in_word.label;

    // words that give no result pass the read stage even when output is full
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!r_s1_ctl.emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    enbm_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (in_acc),
        .o_col       (ctl_col),
        .o_ctl       (ctl)
    );

    // read at the column of the accepted word, write back when it leaves the stage;
    // a column is revisited only after a full row or a frame restart, so no forwarding is needed
    enbm_ram #(
        .WIDTH (2 * LABEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata ({rd_mid, r_s1_lab}),
        .i_re    (in_acc),
        .i_raddr (ctl_col),
        .o_rdata (line_rdata)
    );

    assign rd_top = line_rdata[2*LABEL_BITS-1:LABEL_BITS];
    assign rd_mid = line_rdata[LABEL_BITS-1:0];

    enbm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_ctl   (r_s1_ctl),
        .i_top   (rd_top),
        .i_mid   (rd_mid),
        .i_lab   (r_s1_lab),
        .o_mask  (mask)
    );

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl <= ctl;
            r_s1_col <= ctl_col;
            r_s1_lab <= in_lab;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_ctl.emit) begin
            r_out_word.border_mask  <= mask;
            r_out_word.end_of_frame <= r_s1_ctl.eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a held output word must never be overwritten
    `ASSERT_IMPLY(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, !(s1_adv && r_s1_ctl.emit))
    // write-back and new read meet on one column only across a frame restart
    `ASSERT_IMPLY(a_no_rw_clash, i_clk, i_rst_n, s1_adv && in_acc && (r_s1_col == ctl_col), r_s1_col == '0)

endmodule
